// File: rtl/core/adih_pkg.sv
package adih_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int STATE_WIDTH   = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LP_FEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LP_BACK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_FEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HP_BACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd6;

  localparam logic signed [31:0] RST_LP_FEED   = 32'sd145765821;
  localparam logic signed [31:0] RST_LP_BACK   = -32'sd782210179;
  localparam logic signed [31:0] RST_HP_FEED   = 32'sd1063716297;
  localparam logic signed [31:0] RST_HP_BACK   = -32'sd1053690769;
  localparam logic [30:0]        RST_VEL_GAIN  = 31'd52667036;
  localparam logic [30:0]        RST_DISP_GAIN = 31'd5368709;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd9;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_MAG = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LO  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HI  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RND = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ACC = 3'd4;

  typedef struct packed {
    logic               load_in;
    logic               run;
    logic [STEP_W-1:0]  step;
    logic [PHASE_W-1:0] phase;
    logic               axis;
    logic               commit;
    logic               load_out;
  } adih_cmd_t;

  typedef struct packed {
    logic enable;
  } adih_stat_t;

endpackage

// File: rtl/core/adih_chan_if.sv
interface adih_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x_mg;
  logic signed [15:0] accel_y_mg;
  logic               read_failed;

  modport source(output valid, output accel_x_mg, output accel_y_mg, output read_failed,
                 input ready);
  modport sink(input valid, input accel_x_mg, input accel_y_mg, input read_failed,
               output ready);
endinterface

interface adih_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] raw_x;
  logic signed [31:0] smooth_x;
  logic signed [31:0] vel_x;
  logic signed [31:0] disp_x;
  logic signed [15:0] raw_y;
  logic signed [31:0] smooth_y;
  logic signed [31:0] vel_y;
  logic signed [31:0] disp_y;

  modport source(output valid, output raw_x, output smooth_x, output vel_x, output disp_x,
                 output raw_y, output smooth_y, output vel_y, output disp_y, input ready);
  modport sink(input valid, input raw_x, input smooth_x, input vel_x, input disp_x,
               input raw_y, input smooth_y, input vel_y, input disp_y, output ready);
endinterface

// File: rtl/core/accel_double_integrator_hpf_core.sv
// sequence: 10 products per axis for 2 axes, one after another, each running the
//   phases magnitude, 32x32 low product, high product, round and accumulate
// requests are taken only while idle; a disabled request is accepted and dropped
// the next request is taken while the previous result waits at the output
// reset: synchronous active-low rst_n clears filter state, loads default coefficients
module accel_double_integrator_hpf_core #(
  parameter int FRACTION_BITS = adih_pkg::FRACTION_BITS,
  parameter int STATE_WIDTH   = adih_pkg::STATE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  adih_in_if.sink                         in_ch,
  adih_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [adih_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adih_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  adih_pkg::adih_cmd_t  cmd;
  adih_pkg::adih_stat_t stat;

  adih_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  adih_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .STATE_WIDTH   (STATE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_accel_x_mg  (in_ch.accel_x_mg),
    .in_accel_y_mg  (in_ch.accel_y_mg),
    .in_read_failed (in_ch.read_failed),
    .out_raw_x      (out_ch.raw_x),
    .out_smooth_x   (out_ch.smooth_x),
    .out_vel_x      (out_ch.vel_x),
    .out_disp_x     (out_ch.disp_x),
    .out_raw_y      (out_ch.raw_y),
    .out_smooth_y   (out_ch.smooth_y),
    .out_vel_y      (out_ch.vel_y),
    .out_disp_y     (out_ch.disp_y)
  );

endmodule

// File: rtl/core/adih_ctrl.sv
module adih_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  adih_pkg::adih_stat_t stat,
  output adih_pkg::adih_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [adih_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [adih_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                         axis_r, axis_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         accept;
  logic                         out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.phase     = phase_r;
    cmd.axis      = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.enable) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RUN;
          step_nxt    = '0;
          phase_nxt   = adih_pkg::PH_MAG;
          axis_nxt    = 1'b0;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (phase_r == adih_pkg::PH_ACC) begin
          phase_nxt = adih_pkg::PH_MAG;
          if (step_r == adih_pkg::STEP_LAST) begin
            state_nxt = ST_COMMIT;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      phase_r     <= adih_pkg::PH_MAG;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= adih_pkg::STEP_LAST && phase_r <= adih_pkg::PH_ACC))
    else $error("sequencer out of range");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("result not presented after load");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result overwritten while pending");

endmodule

// File: rtl/core/adih_datapath.sv
module adih_datapath #(
  parameter int FRACTION_BITS = adih_pkg::FRACTION_BITS,
  parameter int STATE_WIDTH   = adih_pkg::STATE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  adih_pkg::adih_cmd_t                 cmd,
  output adih_pkg::adih_stat_t                stat,
  input  logic                                cfg_we,
  input  logic [adih_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adih_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [15:0]                  in_accel_x_mg,
  input  logic signed [15:0]                  in_accel_y_mg,
  input  logic                                in_read_failed,
  output logic signed [15:0]                  out_raw_x,
  output logic signed [31:0]                  out_smooth_x,
  output logic signed [31:0]                  out_vel_x,
  output logic signed [31:0]                  out_disp_x,
  output logic signed [15:0]                  out_raw_y,
  output logic signed [31:0]                  out_smooth_y,
  output logic signed [31:0]                  out_vel_y,
  output logic signed [31:0]                  out_disp_y
);

  localparam int SW = STATE_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int OW = (SW > FB + 18) ? SW : FB + 18;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  localparam logic [3:0] OP_PAIR   = 4'd0;
  localparam logic [3:0] OP_SMOOTH = 4'd1;
  localparam logic [3:0] OP_VNEW   = 4'd2;
  localparam logic [3:0] OP_VOLD   = 4'd3;
  localparam logic [3:0] OP_VFP    = 4'd4;
  localparam logic [3:0] OP_VSUM   = 4'd5;
  localparam logic [3:0] OP_DNEW   = 4'd6;
  localparam logic [3:0] OP_DOLD   = 4'd7;
  localparam logic [3:0] OP_DFP    = 4'd8;

  localparam logic [2:0] C_LPF = 3'd0;
  localparam logic [2:0] C_LPB = 3'd1;
  localparam logic [2:0] C_VG  = 3'd2;
  localparam logic [2:0] C_HF  = 3'd3;
  localparam logic [2:0] C_NHF = 3'd4;
  localparam logic [2:0] C_HB  = 3'd5;
  localparam logic [2:0] C_DG  = 3'd6;

  localparam logic [1:0] B_ZERO = 2'd0;
  localparam logic [1:0] B_ACC  = 2'd1;
  localparam logic [1:0] B_VACC = 2'd2;
  localparam logic [1:0] B_DACC = 2'd3;

  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_S    = 3'd1;
  localparam logic [2:0] D_V    = 3'd2;
  localparam logic [2:0] D_VF   = 3'd3;
  localparam logic [2:0] D_D    = 3'd4;
  localparam logic [2:0] D_DF   = 3'd5;

  function automatic logic signed [SW-1:0] clamp(input logic signed [SW:0] v);
    if (v[SW] != v[SW-1]) begin
      return v[SW] ? SMIN : SMAX;
    end
    return v[SW-1:0];
  endfunction

  function automatic logic signed [31:0] intpart(input logic signed [SW-1:0] v);
    logic [SW-1:0] vn;
    logic [SW-1:0] mg;
    logic [63:0]   m;
    vn = -v;
    mg = v[SW-1] ? vn : v;
    m  = 64'(mg >> FB);
    if (v[SW-1]) begin
      if (m > 64'h8000_0000) begin
        m = 64'h8000_0000;
      end
      return 32'(-m);
    end
    if (m > 64'h7FFF_FFFF) begin
      m = 64'h7FFF_FFFF;
    end
    return 32'(m);
  endfunction

  logic signed [31:0] lpf_r, lpb_r, hf_r, hb_r;
  logic [30:0]        vg_r, dg_r;
  logic               en_r;

  logic signed [15:0]   x_r, y_r;
  logic signed [15:0]   ps_r [2];
  logic signed [SW-1:0] sm_r [2];
  logic signed [SW-1:0] va_r [2];
  logic signed [SW-1:0] vf_r [2];
  logic signed [SW-1:0] da_r [2];
  logic signed [SW-1:0] df_r [2];

  logic signed [SW-1:0] s_t_r, v_t_r, vf_t_r, d_t_r, df_t_r;
  logic signed [SW-1:0] acc_r;
  logic [OW-1:0]        mv_r;
  logic [31:0]          mc_r;
  logic                 neg_r;
  logic [63:0]          plo_r;
  logic [OW-1:0]        phi_r;
  logic signed [SW-1:0] m_r;

  logic [3:0] op_sel;
  logic [2:0] c_sel;
  logic [1:0] b_sel;
  logic       do_sub;
  logic [2:0] dest;

  logic signed [15:0]   x_cur;
  logic signed [16:0]   psum;
  logic signed [SW-1:0] vsum;
  logic signed [OW-1:0] opv;
  logic [OW-1:0]        opn;
  logic signed [32:0]   cv;
  logic [32:0]          cn;
  logic [OW+32:0]       pr;
  logic [OW+2:0]        q;
  logic [OW+2:0]        lim;
  logic                 sat;
  logic signed [SW-1:0] m_nxt;
  logic signed [SW-1:0] base;
  logic signed [SW:0]   wsum;
  logic signed [SW-1:0] acc_nxt;

  assign stat.enable = en_r;

  always_comb begin
    unique case (cmd.step)
      4'd0: begin op_sel = OP_PAIR;   c_sel = C_LPF; b_sel = B_ZERO; do_sub = 1'b0; dest = D_NONE; end
      4'd1: begin op_sel = OP_SMOOTH; c_sel = C_LPB; b_sel = B_ACC;  do_sub = 1'b1; dest = D_S;    end
      4'd2: begin op_sel = OP_PAIR;   c_sel = C_VG;  b_sel = B_VACC; do_sub = 1'b0; dest = D_V;    end
      4'd3: begin op_sel = OP_VNEW;   c_sel = C_HF;  b_sel = B_ZERO; do_sub = 1'b0; dest = D_NONE; end
      4'd4: begin op_sel = OP_VOLD;   c_sel = C_NHF; b_sel = B_ACC;  do_sub = 1'b0; dest = D_NONE; end
      4'd5: begin op_sel = OP_VFP;    c_sel = C_HB;  b_sel = B_ACC;  do_sub = 1'b1; dest = D_VF;   end
      4'd6: begin op_sel = OP_VSUM;   c_sel = C_DG;  b_sel = B_DACC; do_sub = 1'b0; dest = D_D;    end
      4'd7: begin op_sel = OP_DNEW;   c_sel = C_HF;  b_sel = B_ZERO; do_sub = 1'b0; dest = D_NONE; end
      4'd8: begin op_sel = OP_DOLD;   c_sel = C_NHF; b_sel = B_ACC;  do_sub = 1'b0; dest = D_NONE; end
      4'd9: begin op_sel = OP_DFP;    c_sel = C_HB;  b_sel = B_ACC;  do_sub = 1'b1; dest = D_DF;   end
      default: begin
        op_sel = OP_PAIR; c_sel = C_LPF; b_sel = B_ZERO; do_sub = 1'b0; dest = D_NONE;
      end
    endcase
  end

  always_comb begin
    x_cur = cmd.axis ? y_r : x_r;
    psum  = 17'(x_cur) + 17'(ps_r[cmd.axis]);
    vsum  = clamp((SW+1)'(vf_t_r) + (SW+1)'(vf_r[cmd.axis]));
    case (op_sel)
      OP_PAIR:   opv = OW'(psum) <<< FB;
      OP_SMOOTH: opv = OW'(sm_r[cmd.axis]);
      OP_VNEW:   opv = OW'(v_t_r);
      OP_VOLD:   opv = OW'(va_r[cmd.axis]);
      OP_VFP:    opv = OW'(vf_r[cmd.axis]);
      OP_VSUM:   opv = OW'(vsum);
      OP_DNEW:   opv = OW'(d_t_r);
      OP_DOLD:   opv = OW'(da_r[cmd.axis]);
      OP_DFP:    opv = OW'(df_r[cmd.axis]);
      default:   opv = '0;
    endcase
    opn = -opv;
    case (c_sel)
      C_LPF:   cv = 33'(lpf_r);
      C_LPB:   cv = 33'(lpb_r);
      C_VG:    cv = {2'b00, vg_r};
      C_HF:    cv = 33'(hf_r);
      C_NHF:   cv = -33'(hf_r);
      C_HB:    cv = 33'(hb_r);
      C_DG:    cv = {2'b00, dg_r};
      default: cv = '0;
    endcase
    cn = -cv;
  end

  always_comb begin
    pr    = {1'b0, phi_r, 32'b0} + (OW+33)'(plo_r) + ((OW+33)'(1) << 29);
    q     = pr[OW+32:30];
    lim   = neg_r ? ((OW+3)'(1) << (SW-1)) : (((OW+3)'(1) << (SW-1)) - 1'b1);
    sat   = q > lim;
    if (neg_r) begin
      m_nxt = sat ? SMIN : -(q[SW-1:0]);
    end else begin
      m_nxt = sat ? SMAX : q[SW-1:0];
    end
    case (b_sel)
      B_ZERO:  base = '0;
      B_ACC:   base = acc_r;
      B_VACC:  base = va_r[cmd.axis];
      B_DACC:  base = da_r[cmd.axis];
      default: base = '0;
    endcase
    wsum    = do_sub ? ((SW+1)'(base) - (SW+1)'(m_r)) : ((SW+1)'(base) + (SW+1)'(m_r));
    acc_nxt = clamp(wsum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpf_r <= adih_pkg::RST_LP_FEED;
      lpb_r <= adih_pkg::RST_LP_BACK;
      hf_r  <= adih_pkg::RST_HP_FEED;
      hb_r  <= adih_pkg::RST_HP_BACK;
      vg_r  <= adih_pkg::RST_VEL_GAIN;
      dg_r  <= adih_pkg::RST_DISP_GAIN;
      en_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adih_pkg::REG_LP_FEED:   lpf_r <= cfg_wdata[31:0];
        adih_pkg::REG_LP_BACK:   lpb_r <= cfg_wdata[31:0];
        adih_pkg::REG_HP_FEED:   hf_r  <= cfg_wdata[31:0];
        adih_pkg::REG_HP_BACK:   hb_r  <= cfg_wdata[31:0];
        adih_pkg::REG_VEL_GAIN:  vg_r  <= cfg_wdata[30:0];
        adih_pkg::REG_DISP_GAIN: dg_r  <= cfg_wdata[30:0];
        adih_pkg::REG_ENABLE:    en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        ps_r[i] <= '0;
        sm_r[i] <= '0;
        va_r[i] <= '0;
        vf_r[i] <= '0;
        da_r[i] <= '0;
        df_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      ps_r[cmd.axis] <= x_cur;
      sm_r[cmd.axis] <= s_t_r;
      va_r[cmd.axis] <= v_t_r;
      vf_r[cmd.axis] <= vf_t_r;
      da_r[cmd.axis] <= d_t_r;
      df_r[cmd.axis] <= df_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= in_read_failed ? 16'sd0 : in_accel_x_mg;
      y_r <= in_read_failed ? 16'sd0 : in_accel_y_mg;
    end
    if (cmd.run) begin
      case (cmd.phase)
        adih_pkg::PH_MAG: begin
          mv_r  <= opv[OW-1] ? opn : opv;
          mc_r  <= cv[32] ? cn[31:0] : cv[31:0];
          neg_r <= opv[OW-1] ^ cv[32];
        end
        adih_pkg::PH_LO:  plo_r <= 64'(mv_r[31:0]) * 64'(mc_r);
        adih_pkg::PH_HI:  phi_r <= OW'(mv_r[OW-1:32]) * OW'(mc_r);
        adih_pkg::PH_RND: m_r <= m_nxt;
        adih_pkg::PH_ACC: begin
          acc_r <= acc_nxt;
          case (dest)
            D_S:     s_t_r  <= acc_nxt;
            D_V:     v_t_r  <= acc_nxt;
            D_VF:    vf_t_r <= acc_nxt;
            D_D:     d_t_r  <= acc_nxt;
            D_DF:    df_t_r <= acc_nxt;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_raw_x    <= ps_r[0];
      out_smooth_x <= intpart(sm_r[0]);
      out_vel_x    <= intpart(vf_r[0]);
      out_disp_x   <= intpart(df_r[0]);
      out_raw_y    <= ps_r[1];
      out_smooth_y <= intpart(sm_r[1]);
      out_vel_y    <= intpart(vf_r[1]);
      out_disp_y   <= intpart(df_r[1]);
    end
  end

endmodule

// File: tb/sv/accel_double_integrator_hpf_core_tb.sv
module accel_double_integrator_hpf_core_tb;

  localparam logic [adih_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint SMAX = (longint'(1) <<< (adih_pkg::STATE_WIDTH - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 120;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic               failed;
  } sample_t;

  typedef struct {
    logic signed [15:0] raw_x;
    logic signed [31:0] smooth_x;
    logic signed [31:0] vel_x;
    logic signed [31:0] disp_x;
    logic signed [15:0] raw_y;
    logic signed [31:0] smooth_y;
    logic signed [31:0] vel_y;
    logic signed [31:0] disp_y;
  } motion_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [adih_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [adih_pkg::CFG_DATA_W-1:0] cfg_wdata;

  adih_in_if in_ch ();
  adih_out_if out_ch ();

  accel_double_integrator_hpf_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sample_t samples_pending[$];
  motion_t motion_expected[$];
  sample_t sample_on_bus;
  int errors;
  int cycles;
  bit no_idle;
  bit start_hold;

  longint lp_feed, lp_back, hp_feed, hp_back, vel_gain, disp_gain;
  bit enabled;
  longint last_acc[2], last_smooth[2], vel_acc[2], last_vel[2], last_vel_f[2];
  longint disp_acc[2], last_disp[2], last_disp_f[2];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_state(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint scale_q30(longint v, longint c);
    logic neg;
    logic [127:0] p;
    neg = (v < 0) != (c < 0);
    p = 128'(magnitude(v)) * 128'(magnitude(c));
    p = (p + (128'd1 << 29)) >> 30;
    if (neg) begin
      if (p > 128'(SMAX) + 1) return SMIN;
      return -longint'(p[63:0]);
    end
    if (p > 128'(SMAX)) return SMAX;
    return longint'(p[63:0]);
  endfunction

  function automatic longint highpass(longint cur, longint prev_in, longint prev_out);
    longint t;
    t = clamp_state(scale_q30(cur, hp_feed) + scale_q30(prev_in, -hp_feed));
    return clamp_state(t - scale_q30(prev_out, hp_back));
  endfunction

  function automatic logic [31:0] int_part(longint v);
    longint m;
    m = magnitude(v) >>> adih_pkg::FRACTION_BITS;
    if (v < 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-m);
    end
    if (m > 64'h7fff_ffff) m = 64'h7fff_ffff;
    return 32'(m);
  endfunction

  task automatic integrate_axis(int a, longint x, output logic [31:0] sm,
                                output logic [31:0] vf_i, output logic [31:0] df_i);
    longint pair, s, v, vf, d, df;
    pair = (x + last_acc[a]) * (longint'(1) <<< adih_pkg::FRACTION_BITS);
    s = clamp_state(scale_q30(pair, lp_feed) - scale_q30(last_smooth[a], lp_back));
    v = clamp_state(vel_acc[a] + scale_q30(pair, vel_gain));
    vf = highpass(v, last_vel[a], last_vel_f[a]);
    d = clamp_state(disp_acc[a] +
                    scale_q30(clamp_state(vf + last_vel_f[a]), disp_gain));
    df = highpass(d, last_disp[a], last_disp_f[a]);
    last_acc[a] = x;
    last_smooth[a] = s;
    vel_acc[a] = v;
    last_vel[a] = v;
    last_vel_f[a] = vf;
    disp_acc[a] = d;
    last_disp[a] = d;
    last_disp_f[a] = df;
    sm = int_part(s);
    vf_i = int_part(vf);
    df_i = int_part(df);
  endtask

  task automatic predict_motion(sample_t smp);
    motion_t m;
    longint x, y;
    if (!enabled) return;
    x = smp.failed ? 0 : longint'(smp.ax);
    y = smp.failed ? 0 : longint'(smp.ay);
    m.raw_x = 16'(x);
    m.raw_y = 16'(y);
    integrate_axis(0, x, m.smooth_x, m.vel_x, m.disp_x);
    integrate_axis(1, y, m.smooth_y, m.vel_y, m.disp_y);
    motion_expected.push_back(m);
  endtask

  // driver
  int src_gap;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_motion(sample_on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (samples_pending.size() > 0) begin
          sample_on_bus = samples_pending.pop_front();
          in_ch.accel_x_mg <= sample_on_bus.ax;
          in_ch.accel_y_mg <= sample_on_bus.ay;
          in_ch.read_failed <= sample_on_bus.failed;
          in_ch.valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      errors++;
    end
  endtask

  // monitor
  int sink_gap;
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (motion_expected.size() == 0) begin
          $error("unexpected result request");
          errors++;
        end else begin
          motion_t e;
          e = motion_expected.pop_front();
          check_field("raw_x", 32'(e.raw_x), 32'(out_ch.raw_x));
          check_field("smooth_x", e.smooth_x, out_ch.smooth_x);
          check_field("vel_x", e.vel_x, out_ch.vel_x);
          check_field("disp_x", e.disp_x, out_ch.disp_x);
          check_field("raw_y", 32'(e.raw_y), 32'(out_ch.raw_y));
          check_field("smooth_y", e.smooth_y, out_ch.smooth_y);
          check_field("vel_y", e.vel_y, out_ch.vel_y);
          check_field("disp_y", e.disp_y, out_ch.disp_y);
        end
      end
      if (start_hold && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 3000;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [adih_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      adih_pkg::REG_LP_FEED:   lp_feed = longint'($signed(val));
      adih_pkg::REG_LP_BACK:   lp_back = longint'($signed(val));
      adih_pkg::REG_HP_FEED:   hp_feed = longint'($signed(val));
      adih_pkg::REG_HP_BACK:   hp_back = longint'($signed(val));
      adih_pkg::REG_VEL_GAIN:  vel_gain = longint'(val[30:0]);
      adih_pkg::REG_DISP_GAIN: disp_gain = longint'(val[30:0]);
      adih_pkg::REG_ENABLE:    enabled = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (samples_pending.size() != 0 || in_ch.valid || motion_expected.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_sample(int x, int y, bit f);
    sample_t s;
    s.ax = 16'(x);
    s.ay = 16'(y);
    s.failed = f;
    samples_pending.push_back(s);
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: add_sample($urandom, $urandom, 1'b1);
        1, 2: add_sample($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100, 1'b0);
        3: add_sample($urandom_range(0, 1) ? 32767 : -32768,
                      $urandom_range(0, 1) ? 32767 : -32768, 1'b0);
        default: add_sample($urandom, $urandom, 1'b0);
      endcase
    end
  endtask

  task automatic load_defaults();
    write_reg(adih_pkg::REG_LP_FEED, adih_pkg::RST_LP_FEED);
    write_reg(adih_pkg::REG_LP_BACK, adih_pkg::RST_LP_BACK);
    write_reg(adih_pkg::REG_HP_FEED, adih_pkg::RST_HP_FEED);
    write_reg(adih_pkg::REG_HP_BACK, adih_pkg::RST_HP_BACK);
    write_reg(adih_pkg::REG_VEL_GAIN, {1'b0, adih_pkg::RST_VEL_GAIN});
    write_reg(adih_pkg::REG_DISP_GAIN, {1'b0, adih_pkg::RST_DISP_GAIN});
    write_reg(adih_pkg::REG_ENABLE, 32'd1);
    end_writes();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.accel_x_mg = '0;
    in_ch.accel_y_mg = '0;
    in_ch.read_failed = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    cycles = 0;
    no_idle = 0;
    start_hold = 0;
    hold_done = 0;
    hold_left = 0;
    src_gap = 0;
    sink_gap = 0;
    lp_feed = adih_pkg::RST_LP_FEED;
    lp_back = adih_pkg::RST_LP_BACK;
    hp_feed = adih_pkg::RST_HP_FEED;
    hp_back = adih_pkg::RST_HP_BACK;
    vel_gain = adih_pkg::RST_VEL_GAIN;
    disp_gain = adih_pkg::RST_DISP_GAIN;
    enabled = 1;
    for (int a = 0; a < 2; a++) begin
      last_acc[a] = 0; last_smooth[a] = 0; vel_acc[a] = 0; last_vel[a] = 0;
      last_vel_f[a] = 0; disp_acc[a] = 0; last_disp[a] = 0; last_disp_f[a] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, failed reads, sign flips
    add_sample(0, 0, 0);
    add_sample(32767, -32768, 0);
    add_sample(32767, -32768, 0);
    add_sample(-32768, 32767, 0);
    add_sample(-1, 1, 0);
    add_sample(32767, 32767, 1);
    add_sample(-32768, -1, 1);
    add_sample(12345, -12345, 0);
    repeat (6) add_sample(32767, 32767, 0);
    repeat (6) add_sample(-32768, -32768, 0);
    add_sample(0, 0, 1);
    add_sample(1, -1, 0);
    add_random(230);
    wait_idle();

    // saturating coefficients, gain bit 31 must be dropped
    write_reg(adih_pkg::REG_LP_FEED, 32'h7fff_ffff);
    write_reg(adih_pkg::REG_LP_BACK, 32'h8000_0000);
    write_reg(adih_pkg::REG_HP_FEED, 32'h8000_0000);
    write_reg(adih_pkg::REG_HP_BACK, 32'h7fff_ffff);
    write_reg(adih_pkg::REG_VEL_GAIN, 32'hffff_ffff);
    write_reg(adih_pkg::REG_DISP_GAIN, 32'hffff_ffff);
    write_reg(REG_SPARE, 32'h0);
    end_writes();
    add_random(60);
    wait_idle();

    write_reg(adih_pkg::REG_ENABLE, 32'h0000_fffe);
    end_writes();
    add_random(30);
    wait_idle();

    write_reg(adih_pkg::REG_LP_FEED, 32'h0);
    write_reg(adih_pkg::REG_LP_BACK, 32'h0);
    write_reg(adih_pkg::REG_HP_FEED, 32'h4000_0000);
    write_reg(adih_pkg::REG_HP_BACK, 32'h0);
    write_reg(adih_pkg::REG_VEL_GAIN, 32'h0);
    write_reg(adih_pkg::REG_DISP_GAIN, 32'h0);
    write_reg(adih_pkg::REG_ENABLE, 32'h1);
    end_writes();
    add_random(40);
    wait_idle();

    write_reg(adih_pkg::REG_LP_FEED, $urandom);
    write_reg(adih_pkg::REG_LP_BACK, $urandom);
    write_reg(adih_pkg::REG_HP_FEED, $urandom);
    write_reg(adih_pkg::REG_HP_BACK, $urandom);
    write_reg(adih_pkg::REG_VEL_GAIN, $urandom);
    write_reg(adih_pkg::REG_DISP_GAIN, $urandom);
    end_writes();
    add_random(220);
    repeat (400) @(posedge clk);
    start_hold = 1;
    wait_idle();

    load_defaults();
    no_idle = 1;
    add_random(250);
    wait_idle();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/adih_pkg.sv
rtl/core/adih_chan_if.sv
rtl/core/adih_ctrl.sv
rtl/core/adih_datapath.sv
rtl/core/accel_double_integrator_hpf_core.sv
tb/sv/accel_double_integrator_hpf_core_tb.sv
